>>> design/rotated_box_ray_intersection_core_assert.svh
// Assertion macros used by the checker file of the rotated box intersector.
`ifndef ROTATED_BOX_RAY_INTERSECTION_CORE_ASSERT_SVH
`define ROTATED_BOX_RAY_INTERSECTION_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled while rst_n is low.
`define RBRI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled while rst_n is low.
`define RBRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rbri_pkg.sv
// Shared widths, constants and types of the rotated box intersector.
`timescale 1ns / 1ps
package rbri_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W     = 32;
    localparam int DIR_W     = 18;
    localparam int TRIG_W    = 18;
    localparam int DIST_W    = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int AXES  = 3;
    localparam int LANES = 2 * AXES;

    // translated origin and rotation products
    localparam int T_W     = POS_W + 1;
    localparam int PROD_W  = T_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int O_W     = (SUM_W - FRAC_BITS > T_W + 1) ? SUM_W - FRAC_BITS : T_W + 1;
    localparam int DPROD_W = DIR_W + TRIG_W;
    localparam int DSUM_W  = DPROD_W + 1;
    localparam int DL_W    = (DSUM_W - FRAC_BITS > DIR_W + 1) ? DSUM_W - FRAC_BITS : DIR_W + 1;

    // slab numerators and divider
    localparam int N_W   = O_W + 1;
    localparam int QUO_W = DIST_W + 1;
    localparam int CMP_W = (N_W + FRAC_BITS > DL_W + QUO_W) ? N_W + FRAC_BITS : DL_W + QUO_W;
    localparam int VAL_W = QUO_W + 1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(1) << DIST_W;
    localparam logic signed [VAL_W-1:0] VAL_MIN = -VAL_MAX;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EDGE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE = CFG_IDX_W'(5);

    localparam logic [DIST_W-1:0]        HALF_EDGE_RST = DIST_W'(32768);
    localparam logic signed [TRIG_W-1:0] COS_RST       = TRIG_W'(65536);
    localparam logic signed [TRIG_W-1:0] SIN_RST       = '0;

    // per-item sideband that travels alongside the divider lanes
    typedef struct packed {
        logic [DIST_W-1:0] best;
        logic [LANES-1:0]  neg;
        logic [AXES-1:0]   par;
        logic              miss;
    } side_t;

endpackage

>>> design/rbri_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating at the top bit.
`timescale 1ns / 1ps
module rbri_div
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [rbri_pkg::N_W-1:0]    dividend,
    input  logic [rbri_pkg::DL_W-1:0]   divisor,
    output logic [rbri_pkg::QUO_W-1:0]  quotient
);
    import rbri_pkg::*;

    logic [CMP_W-1:0] rem_reg [QUO_W-1];
    logic [DL_W-1:0]  dvs_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [CMP_W-1:0] rem_in;
        logic [DL_W-1:0]  dvs_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W:0]   trial;

        if (s == 0) begin : g_first
            // dividend is scaled by the fraction before the divide
            assign rem_in = CMP_W'(dividend) << FRAC_BITS;
            assign dvs_in = divisor;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial = {1'b0, rem_in} - ((CMP_W + 1)'(dvs_in) << (QUO_W - 1 - s));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= {quo_in[QUO_W-2:0], ~trial[CMP_W]};
            end
        end

        if (s < QUO_W - 1) begin : g_carry
            logic [CMP_W-1:0] rem_next;

            assign rem_next = trial[CMP_W] ? rem_in : trial[CMP_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    dvs_reg[s] <= dvs_in;
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];

endmodule

>>> design/rotated_box_ray_intersection_core.sv
// Top level of the rotated box / ray slab intersector.
`timescale 1ns / 1ps
// Takes one ray per cycle and reports whether it enters a cube, turned about Y by the
// configured cosine and sine and centered at the configured point, nearer than the given
// best distance. Positions are signed Q16.16, directions, cosine and sine signed Q2.16 and
// distances unsigned Q15.16. The pipeline is 38 stages long: one translate stage, one
// multiply stage, one rotate stage, one slab setup stage, 32 stages of six parallel
// one-bit-per-stage dividers (entry and exit per axis), one combine stage and the output
// register; a new ray is accepted in every cycle while results are taken. The dividers
// set the depth. A two-entry output (register plus skid) lets the pipe keep taking rays
// after the consumer stalls until a result lands in the skid; in_ready drops only when
// both entries hold results. Configuration writes take effect at once and are meant to be
// issued only while no ray is in flight.
module rotated_box_ray_intersection_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write,
    input  logic [rbri_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rbri_pkg::CFG_W-1:0]             cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [rbri_pkg::POS_W-1:0]      origin_x,
    input  logic signed [rbri_pkg::POS_W-1:0]      origin_y,
    input  logic signed [rbri_pkg::POS_W-1:0]      origin_z,
    input  logic signed [rbri_pkg::DIR_W-1:0]      dir_x,
    input  logic signed [rbri_pkg::DIR_W-1:0]      dir_y,
    input  logic signed [rbri_pkg::DIR_W-1:0]      dir_z,
    input  logic [rbri_pkg::DIST_W-1:0]            best_distance,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   hit,
    output logic [rbri_pkg::DIST_W-1:0]            new_distance
);
    import rbri_pkg::*;

    // ---------------------------------------------------------------- configuration
    logic signed [POS_W-1:0]  center_x_reg;
    logic signed [POS_W-1:0]  center_y_reg;
    logic signed [POS_W-1:0]  center_z_reg;
    logic [DIST_W-1:0]        half_edge_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            half_edge_reg <= HALF_EDGE_RST;
            cos_reg       <= COS_RST;
            sin_reg       <= SIN_RST;
        end
        else if (cfg_write)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                REG_CENTER_X:  center_x_reg  <= cfg_data[POS_W-1:0];
                REG_CENTER_Y:  center_y_reg  <= cfg_data[POS_W-1:0];
                REG_CENTER_Z:  center_z_reg  <= cfg_data[POS_W-1:0];
                REG_HALF_EDGE: half_edge_reg <= cfg_data[DIST_W-1:0];
                REG_COS_ANGLE: cos_reg       <= cfg_data[TRIG_W-1:0];
                REG_SIN_ANGLE: sin_reg       <= cfg_data[TRIG_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // The whole pipe advances together; it halts only when the skid entry is full,
    // which always leaves room for the item leaving the last stage.
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    logic take;
    assign take = in_valid && en;

    // ---------------------------------------------------------------- stage 1: translate
    logic                    v1_reg;
    logic signed [T_W-1:0]   tx1_reg, ty1_reg, tz1_reg;
    logic signed [DIR_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [DIST_W-1:0]       best1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx1_reg   <= T_W'(origin_x) - T_W'(center_x_reg);
            ty1_reg   <= T_W'(origin_y) - T_W'(center_y_reg);
            tz1_reg   <= T_W'(origin_z) - T_W'(center_z_reg);
            dx1_reg   <= dir_x;
            dy1_reg   <= dir_y;
            dz1_reg   <= dir_z;
            best1_reg <= best_distance;
        end
    end

    // ---------------------------------------------------------------- stage 2: multiply
    logic                     v2_reg;
    logic signed [PROD_W-1:0] pxc2_reg, pzs2_reg, pzc2_reg, pxs2_reg;
    logic signed [DPROD_W-1:0] qxc2_reg, qzs2_reg, qzc2_reg, qxs2_reg;
    logic signed [T_W-1:0]    ty2_reg;
    logic signed [DIR_W-1:0]  dy2_reg;
    logic [DIST_W-1:0]        best2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxc2_reg  <= PROD_W'(tx1_reg) * PROD_W'(cos_reg);
            pzs2_reg  <= PROD_W'(tz1_reg) * PROD_W'(sin_reg);
            pzc2_reg  <= PROD_W'(tz1_reg) * PROD_W'(cos_reg);
            pxs2_reg  <= PROD_W'(tx1_reg) * PROD_W'(sin_reg);
            qxc2_reg  <= DPROD_W'(dx1_reg) * DPROD_W'(cos_reg);
            qzs2_reg  <= DPROD_W'(dz1_reg) * DPROD_W'(sin_reg);
            qzc2_reg  <= DPROD_W'(dz1_reg) * DPROD_W'(cos_reg);
            qxs2_reg  <= DPROD_W'(dx1_reg) * DPROD_W'(sin_reg);
            ty2_reg   <= ty1_reg;
            dy2_reg   <= dy1_reg;
            best2_reg <= best1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3: rotate
    // Arithmetic right shift rounds toward minus infinity.
    logic signed [SUM_W-1:0]  sox_c, soz_c;
    logic signed [DSUM_W-1:0] sdx_c, sdz_c;

    assign sox_c = SUM_W'(pxc2_reg) + SUM_W'(pzs2_reg);
    assign soz_c = SUM_W'(pzc2_reg) - SUM_W'(pxs2_reg);
    assign sdx_c = DSUM_W'(qxc2_reg) + DSUM_W'(qzs2_reg);
    assign sdz_c = DSUM_W'(qzc2_reg) - DSUM_W'(qxs2_reg);

    logic                    v3_reg;
    logic signed [O_W-1:0]   org3_reg [AXES];
    logic signed [DL_W-1:0]  dir3_reg [AXES];
    logic [DIST_W-1:0]       best3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            org3_reg[0] <= O_W'(sox_c >>> FRAC_BITS);
            org3_reg[1] <= O_W'(ty2_reg);
            org3_reg[2] <= O_W'(soz_c >>> FRAC_BITS);
            dir3_reg[0] <= DL_W'(sdx_c >>> FRAC_BITS);
            dir3_reg[1] <= DL_W'(dy2_reg);
            dir3_reg[2] <= DL_W'(sdz_c >>> FRAC_BITS);
            best3_reg   <= best2_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4: slab setup
    // Entry numerator is the near bound for the ray's sign; magnitudes go to the
    // dividers and the quotient signs ride along in the sideband.
    logic signed [N_W-1:0] hs_c;
    logic signed [N_W-1:0] os_c    [AXES];
    logic signed [N_W-1:0] lo_num_c [AXES];
    logic signed [N_W-1:0] hi_num_c [AXES];
    logic signed [N_W-1:0] ent_c   [AXES];
    logic signed [N_W-1:0] ext_c   [AXES];
    logic [AXES-1:0]       dneg_c;
    logic [AXES-1:0]       dzero_c;
    logic [AXES-1:0]       out_slab_c;
    logic [N_W-1:0]        nmag_c  [LANES];
    logic [DL_W-1:0]       dmag_c  [AXES];
    logic [LANES-1:0]      neg_c;

    assign hs_c = $signed(N_W'(half_edge_reg));

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            os_c[a]       = N_W'(org3_reg[a]);
            lo_num_c[a]   = -hs_c - os_c[a];
            hi_num_c[a]   = hs_c - os_c[a];
            dneg_c[a]     = dir3_reg[a][DL_W-1];
            dzero_c[a]    = (dir3_reg[a] == '0);
            out_slab_c[a] = (os_c[a] < -hs_c) || (os_c[a] > hs_c);
            ent_c[a]      = dneg_c[a] ? hi_num_c[a] : lo_num_c[a];
            ext_c[a]      = dneg_c[a] ? lo_num_c[a] : hi_num_c[a];
            dmag_c[a]     = dneg_c[a] ? DL_W'(-dir3_reg[a]) : DL_W'(dir3_reg[a]);
            nmag_c[2*a]     = ent_c[a][N_W-1] ? N_W'(-ent_c[a]) : N_W'(ent_c[a]);
            nmag_c[2*a + 1] = ext_c[a][N_W-1] ? N_W'(-ext_c[a]) : N_W'(ext_c[a]);
            neg_c[2*a]      = ent_c[a][N_W-1] ^ dneg_c[a];
            neg_c[2*a + 1]  = ext_c[a][N_W-1] ^ dneg_c[a];
        end
    end

    logic             v4_reg;
    logic [N_W-1:0]   nmag4_reg [LANES];
    logic [DL_W-1:0]  dmag4_reg [AXES];
    side_t            side4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag4_reg      <= nmag_c;
            dmag4_reg      <= dmag_c;
            side4_reg.best <= best3_reg;
            side4_reg.neg  <= neg_c;
            side4_reg.par  <= dzero_c;
            side4_reg.miss <= |(dzero_c & out_slab_c);
        end
    end

    // ---------------------------------------------------------------- divider lanes
    logic [QUO_W-1:0] quo_c [LANES];

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        rbri_div u_div
        (
            .clk      (clk),
            .en       (en),
            .dividend (nmag4_reg[i]),
            .divisor  (dmag4_reg[i/2]),
            .quotient (quo_c[i])
        );
    end

    logic [QUO_W-1:0] dv_valid_reg;
    side_t            side_reg [QUO_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side4_reg;
            for (int s = 1; s < QUO_W; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------- combine
    // Quotients of 2^31 or more clamp to 2^31; that keeps every comparison below exact
    // wherever a hit is possible.
    logic signed [VAL_W-1:0] sval_c [LANES];
    logic signed [VAL_W-1:0] lo_c;
    logic signed [VAL_W-1:0] hi_c;
    side_t                   side_last;

    assign side_last = side_reg[QUO_W-1];

    always_comb
    begin
        logic signed [VAL_W-1:0] vmag;
        logic signed [VAL_W-1:0] ent;
        logic signed [VAL_W-1:0] ext;
        for (int i = 0; i < LANES; i++)
        begin
            vmag      = quo_c[i][QUO_W-1] ? VAL_MAX : $signed(VAL_W'(quo_c[i][QUO_W-2:0]));
            sval_c[i] = side_last.neg[i] ? -vmag : vmag;
        end
        lo_c = VAL_MIN;
        hi_c = VAL_MAX;
        for (int a = 0; a < AXES; a++)
        begin
            ent = side_last.par[a] ? VAL_MIN : sval_c[2*a];
            ext = side_last.par[a] ? VAL_MAX : sval_c[2*a + 1];
            if (ent > lo_c)
            begin
                lo_c = ent;
            end
            if (ext < hi_c)
            begin
                hi_c = ext;
            end
        end
    end

    logic                    vc_reg;
    logic signed [VAL_W-1:0] lo_reg;
    logic signed [VAL_W-1:0] hi_reg;
    logic                    missc_reg;
    logic [DIST_W-1:0]       bestc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg    <= lo_c;
            hi_reg    <= hi_c;
            missc_reg <= side_last.miss;
            bestc_reg <= side_last.best;
        end
    end

    // ---------------------------------------------------------------- decide
    logic              hit_c;
    logic [DIST_W-1:0] dist_c;

    assign hit_c  = !missc_reg && (lo_reg <= hi_reg) && (lo_reg > 0)
                    && (lo_reg < $signed(VAL_W'(bestc_reg)));
    assign dist_c = hit_c ? lo_reg[DIST_W-1:0] : bestc_reg;

    // ---------------------------------------------------------------- valid line
    logic produce;
    assign produce = vc_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            dv_valid_reg <= '0;
            vc_reg       <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= take;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            dv_valid_reg <= {dv_valid_reg[QUO_W-2:0], v4_reg};
            vc_reg       <= dv_valid_reg[QUO_W-1];
        end
    end

    // ---------------------------------------------------------------- output + skid
    logic              out_hit_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              skid_hit_reg;
    logic [DIST_W-1:0] skid_dist_reg;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // drain the skid first, else take the item leaving the pipe
            out_valid_reg  <= skid_valid_reg || produce;
            skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_hit_reg  <= skid_valid_reg ? skid_hit_reg : hit_c;
            out_dist_reg <= skid_valid_reg ? skid_dist_reg : dist_c;
        end
        else if (produce)
        begin
            skid_hit_reg  <= hit_c;
            skid_dist_reg <= dist_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign new_distance = out_dist_reg;

endmodule

>>> design/rbri_checker.sv
// Port-level checker of the rotated box intersector, bound to the top level.
`timescale 1ns / 1ps
`include "rotated_box_ray_intersection_core_assert.svh"
module rbri_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [rbri_pkg::POS_W-1:0]      origin_x,
    input  logic signed [rbri_pkg::POS_W-1:0]      origin_y,
    input  logic signed [rbri_pkg::POS_W-1:0]      origin_z,
    input  logic signed [rbri_pkg::DIR_W-1:0]      dir_x,
    input  logic signed [rbri_pkg::DIR_W-1:0]      dir_y,
    input  logic signed [rbri_pkg::DIR_W-1:0]      dir_z,
    input  logic [rbri_pkg::DIST_W-1:0]            best_distance,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic                                   hit,
    input  logic [rbri_pkg::DIST_W-1:0]            new_distance
);
    import rbri_pkg::*;

    // hold a stalled ray
    `RBRI_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(origin_x) && $stable(origin_y) && $stable(origin_z)
        && $stable(dir_x) && $stable(dir_y) && $stable(dir_z) && $stable(best_distance),
        "ray changed while stalled")
    // hold a stalled result
    `RBRI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(hit) && $stable(new_distance), "result changed while stalled")
    // a hit always lies strictly in front of the origin
    `RBRI_ASSERT_SAME(a_hit_positive, out_valid && hit, new_distance != '0,
        "hit at zero distance")
    // backpressure only while the output register holds a result
    `RBRI_ASSERT_SAME(a_stall_has_result, !in_ready, out_valid,
        "input stalled with no result pending")
    // a full skid stays full while the consumer waits
    `RBRI_ASSERT_NEXT(a_stall_holds, !in_ready && !out_ready, !in_ready,
        "skid drained without a transfer")

endmodule

bind rotated_box_ray_intersection_core rbri_checker u_rbri_checker (.*);

>>> test/tb_rotated_box_ray_intersection_core.sv
// Self-checking testbench of the rotated box / ray slab intersector.
`timescale 1ns / 1ps
module tb_rotated_box_ray_intersection_core;
    import rbri_pkg::*;

    // one ray and its best distance
    typedef struct {
        logic signed [POS_W-1:0] ox, oy, oz;
        logic signed [DIR_W-1:0] dx, dy, dz;
        logic [DIST_W-1:0]       best;
    } ray_t;

    // one outcome; has_exp marks a directed row with a typed-in result
    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } hit_t;

    typedef struct {
        ray_t ray;
        bit   has_exp;
        hit_t exp;
    } row_t;

    localparam int LATENCY = 38;
    localparam int N_RANDOM = 1000;
    localparam logic signed [DIR_W-1:0] ONE = 18'sd65536;
    localparam logic signed [DIR_W-1:0] MONE = -18'sd65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [POS_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic [DIST_W-1:0] best_distance = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [DIST_W-1:0] new_distance;

    // predictor copy of the registers
    longint box_cx, box_cy, box_cz, box_half, box_cos, box_sin;

    hit_t pending_hits[$];
    int   error_count = 0;
    bit   sink_quiet = 1'b0;   // no random stalls on the result side
    int   sink_hold = 0;       // long hold-off, counted in its own process

    rotated_box_ray_intersection_core uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // floor of v / 2^FRAC_BITS; >>> on longint is arithmetic
    function automatic longint floor_frac(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    // narrow [lo, hi] by one slab; return 0 on a parallel miss
    function automatic bit clip_slab(input longint o, input longint d, input longint h,
                                     inout longint lo, inout longint hi);
        longint a, b, t;
        if (d == 0)
            return (o >= -h) && (o <= h);
        a = ((-h - o) * (64'sd1 <<< FRAC_BITS)) / d;
        b = ((h - o) * (64'sd1 <<< FRAC_BITS)) / d;
        if (a > b)
        begin
            t = a; a = b; b = t;
        end
        if (a > lo) lo = a;
        if (b < hi) hi = b;
        return 1'b1;
    endfunction

    function automatic hit_t predict_entry(input ray_t r);
        longint tx, ty, tz, lox, loz, ldx, ldz, lo, hi;
        bit ok;
        hit_t res;
        tx = longint'(r.ox) - box_cx;
        ty = longint'(r.oy) - box_cy;
        tz = longint'(r.oz) - box_cz;
        lox = floor_frac(tx * box_cos + tz * box_sin);
        loz = floor_frac(tz * box_cos - tx * box_sin);
        ldx = floor_frac(longint'(r.dx) * box_cos + longint'(r.dz) * box_sin);
        ldz = floor_frac(longint'(r.dz) * box_cos - longint'(r.dx) * box_sin);
        lo = -(64'sd1 <<< 62);
        hi = 64'sd1 <<< 62;
        ok = clip_slab(lox, ldx, box_half, lo, hi);
        ok = clip_slab(ty, longint'(r.dy), box_half, lo, hi) && ok;
        ok = clip_slab(loz, ldz, box_half, lo, hi) && ok;
        if (ok && lo <= hi && lo > 0 && lo < longint'(r.best))
        begin
            res.hit = 1'b1;
            res.distance = lo[DIST_W-1:0];
        end
        else
        begin
            res.hit = 1'b0;
            res.distance = r.best;
        end
        return res;
    endfunction

    // write one register at a falling edge; caller ensures the pipe is empty
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_CENTER_X:  box_cx = longint'(signed'(value[31:0]));
            REG_CENTER_Y:  box_cy = longint'(signed'(value[31:0]));
            REG_CENTER_Z:  box_cz = longint'(signed'(value[31:0]));
            REG_HALF_EDGE: box_half = longint'(value[30:0]);
            REG_COS_ANGLE: box_cos = longint'(signed'(value[17:0]));
            REG_SIN_ANGLE: box_sin = longint'(signed'(value[17:0]));
            default: ;
        endcase
    endtask

    task automatic load_box(input longint cx, cy, cz, half, c, s);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_HALF_EDGE, half);
        write_reg(REG_COS_ANGLE, c);
        write_reg(REG_SIN_ANGLE, s);
    endtask

    // wait until all results are back, then let the pipe drain
    task automatic drain_pipe();
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // offer one ray and hold it until the transfer; called at a falling edge
    task automatic send_ray(input ray_t r, input bit has_exp, input hit_t exp, input bit gaps);
        hit_t want;
        while (gaps && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        best_distance <= r.best;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = has_exp ? exp : predict_entry(r);
        pending_hits.push_back(want);
        @(negedge clk);
    endtask

    function automatic logic signed [DIR_W-1:0] rand_dir();
        case ($urandom_range(5))
            0: return '0;
            1: return ONE;
            2: return MONE;
            3: return DIR_W'($urandom);        // full bit pattern, unnormalized
            default: return DIR_W'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    // rays mostly aimed at the box so that hits are frequent
    function automatic ray_t rand_ray();
        ray_t r;
        int spread;
        if ($urandom_range(9) < 7)
        begin
            spread = 1 << $urandom_range(20, 15);
            r.ox = POS_W'(box_cx + $signed($urandom_range(2 * spread)) - spread);
            r.oy = POS_W'(box_cy + $signed($urandom_range(2 * spread)) - spread);
            r.oz = POS_W'(box_cz + $signed($urandom_range(2 * spread)) - spread);
            r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
            r.best = ($urandom_range(3) == 0) ? DIST_W'($urandom_range(1 << 20))
                                              : DIST_W'($urandom);
        end
        else
        begin
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = DIR_W'($urandom); r.dy = DIR_W'($urandom); r.dz = DIR_W'($urandom);
            r.best = DIST_W'($urandom);
        end
        return r;
    endfunction

    function automatic row_t mk(input longint ox, oy, oz, dx, dy, dz, best,
                                input bit has_exp = 1'b0, input bit h = 1'b0,
                                input longint d = 0);
        row_t w;
        w.ray.ox = ox[31:0]; w.ray.oy = oy[31:0]; w.ray.oz = oz[31:0];
        w.ray.dx = dx[17:0]; w.ray.dy = dy[17:0]; w.ray.dz = dz[17:0];
        w.ray.best = best[30:0];
        w.has_exp = has_exp;
        w.exp.hit = h;
        w.exp.distance = d[30:0];
        return w;
    endfunction

    // result side: random stalls, quiet stretches and a long hold-off
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= sink_quiet || ($urandom_range(99) >= 24);
    end

    // check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
                report_mismatch("unexpected result, hit", hit, 0);
            else
            begin
                want = pending_hits.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (new_distance !== want.distance)
                    report_mismatch("new_distance", new_distance, want.distance);
            end
        end
    end

    initial
    begin
        row_t rows[$];
        hit_t none;
        int wait_cycles;
        none = '{1'b0, '0};
        box_cx = 0; box_cy = 0; box_cz = 0;
        box_half = 32768; box_cos = 65536; box_sin = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset box: unit cube of edge 1 at the origin, no rotation
        // straight on along +x from x = -2: entry at 1.5
        rows.push_back(mk(-131072, 0, 0, 65536, 0, 0, 1000000, 1, 1, 98304));
        // same ray, best already nearer: no hit, best passes through
        rows.push_back(mk(-131072, 0, 0, 65536, 0, 0, 98304, 1, 0, 98304));
        // origin inside the box: entry is not positive
        rows.push_back(mk(0, 0, 0, 65536, 0, 0, 1000000, 1, 0, 1000000));
        // box behind the ray
        rows.push_back(mk(-131072, 0, 0, -65536, 0, 0, 1000000, 1, 0, 1000000));
        // parallel slab with origin outside it
        rows.push_back(mk(-131072, 65536, 0, 65536, 0, 0, 1000000, 1, 0, 1000000));
        // parallel slab, origin on the bound: still counts
        rows.push_back(mk(-131072, 32768, 0, 65536, 0, 0, 1000000, 1, 1, 98304));
        // all directions zero with origin inside
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1000000, 1, 0, 1000000));
        // diagonal ray that hits: entry at 1.5, exit at 2
        rows.push_back(mk(-131072, -98304, 0, 65536, 65536, 0, 1000000));
        // misses diagonally, entry after exit
        rows.push_back(mk(-131072, -131072, 0, 65536, -65536, 0, 1000000));
        // field extremes
        rows.push_back(mk(-2147483648, 2147483647, -2147483648, -65536, 65536, -65536,
                          2147483647, 1, 0, 2147483647));
        rows.push_back(mk(2147483647, -2147483648, 2147483647, 65536, -65536, 65536, 0,
                          1, 0, 0));
        rows.push_back(mk(-65536, 0, 0, 1, 0, 0, 2147483647));
        rows.push_back(mk(0, 0, -131072, 0, 0, 131071, 2147483647));
        rows.push_back(mk(0, 0, -131072, 0, 0, -131072, 2147483647));

        foreach (rows[i])
            send_ray(rows[i].ray, rows[i].has_exp, rows[i].exp, 1'b0);
        in_valid <= 1'b0;
        drain_pipe();

        // 45 degree turn about an off-center cube
        load_box(1 << 20, -(1 << 18), 3 << 19, 1 << 17, 46341, 46341);
        rows.delete();
        rows.push_back(mk(1 << 20, -(1 << 18), 0, 0, 0, 65536, 1 << 30));
        rows.push_back(mk(0, -(1 << 18), 3 << 19, 65536, 0, 0, 1 << 30));
        rows.push_back(mk(0, 0, 0, 46341, 0, 46341, 1 << 30));
        foreach (rows[i])
            send_ray(rows[i].ray, 1'b0, none, 1'b0);
        in_valid <= 1'b0;
        drain_pipe();

        // register extremes, out of range trig and a dead index
        load_box(-2147483648, 2147483647, -2147483648, 2147483647, -65536, 65536);
        write_reg(CFG_IDX_W'(7), 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_ray(rand_ray(), 1'b0, none, 1'b0);
        in_valid <= 1'b0;
        drain_pipe();
        load_box(2147483647, -2147483648, 2147483647, 0, 131071, -131072);
        write_reg(CFG_IDX_W'(6), 0);
        for (int i = 0; i < 6; i++)
            send_ray(rand_ray(), 1'b0, none, 1'b0);
        in_valid <= 1'b0;
        drain_pipe();

        // random phases, each under its own box
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 0)
                load_box(0, 0, 0, 32768, 65536, 0);
            else
                load_box($signed($urandom_range(1 << 24)) - (1 << 23),
                         $signed($urandom_range(1 << 24)) - (1 << 23),
                         $signed($urandom_range(1 << 24)) - (1 << 23),
                         (phase == 4) ? $urandom : $urandom_range(1 << 19),
                         $signed($urandom_range(131072)) - 65536,
                         $signed($urandom_range(131072)) - 65536);
            sink_quiet = (phase == 2);
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                // hold off the result side long enough to fill the pipe
                if (phase == 1 && i == 20)
                    sink_hold = 3 * LATENCY;
                // pause the sender until every result is back
                if (phase == 3 && i == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_hits.size() != 0)
                        @(negedge clk);
                end
                send_ray(rand_ray(), 1'b0, none, phase != 2);
            end
            in_valid <= 1'b0;
            drain_pipe();
        end

        wait_cycles = 0;
        while (pending_hits.size() != 0 && wait_cycles < 10000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        if (error_count == 0 && pending_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
